@@ rtl/range_add_assign_sum_tree_assert.svh @@
// Assertion macros for the range add/assign/sum tree.
`ifndef RANGE_ADD_ASSIGN_SUM_TREE_ASSERT_SVH
`define RANGE_ADD_ASSIGN_SUM_TREE_ASSERT_SVH
// Check that cons holds in the same cycle as ante.
`define RAST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Check that cons holds in the cycle after ante.
`define RAST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ rtl/rast_pkg.sv @@
// Shared types, codes and node update function for the range sum tree.
package rast_pkg;

   localparam int RAST_SIZE_DEF = 1024;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_ASSIGN = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VISIT,
      ST_NODE,
      ST_MRD,
      ST_MMUL,
      ST_MWR,
      ST_PUSHP,
      ST_RET,
      ST_POSTL,
      ST_POSTR,
      ST_POSTW,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      KIND_COVER,
      KIND_LEFT,
      KIND_RIGHT
   } kind_type;

   typedef struct packed {
      logic        flag;
      logic [63:0] pend_asg;
      logic [63:0] pend_add;
      logic [63:0] sum;
   } node_type;

   // Apply an add or an assign of w to a node whose span length times w is prod.
   function automatic node_type apply_node(node_type n, logic asg, logic [63:0] w,
                                           logic [63:0] prod);
      node_type r;
      r = n;
      if (asg) begin
         r.flag     = 1'b1;
         r.pend_asg = w;
         r.pend_add = '0;
         r.sum      = prod;
      end else begin
         if (n.flag) begin
            r.pend_asg = n.pend_asg + w;
         end else begin
            r.pend_add = n.pend_add + w;
         end
         r.sum = n.sum + prod;
      end
      return r;
   endfunction

endpackage

@@ rtl/rast_stream_if.sv @@
// Valid/ready channel interfaces for request and response transactions.
interface rast_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [9:0]         range_start;
   logic [9:0]         range_end;
   logic signed [31:0] value;
   modport source (output valid, command, range_start, range_end, value, input ready);
   modport sink   (input valid, command, range_start, range_end, value, output ready);
endinterface

interface rast_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] range_sum;
   modport source (output valid, range_sum, input ready);
   modport sink   (input valid, range_sum, output ready);
endinterface

@@ rtl/range_add_assign_sum_tree.sv @@
// A transaction walks the tree depth first: a skipped node is only read; a fully covered node is
// summed, and for an update rewritten; a partially covered node pushes its pending update down first.
// Throughput: one transaction at a time; the node memory, with one read and one write port, and the shared
// 32-bit multiplier set the pace. A query result waits in an output register.
// Reset: synchronous; afterward a clearing pass zeroes all 4*SIZE entries of the node
// memory, and req_ch.ready stays low until it ends.
module range_add_assign_sum_tree
   import rast_pkg::*;
#(
   parameter int SIZE = RAST_SIZE_DEF
) (
   input logic      clock,
   input logic      reset,
   rast_req_if.sink   req_ch,
   rast_rsp_if.source rsp_ch
);

`include "range_add_assign_sum_tree_assert.svh"

   localparam int IDX_W  = $clog2(SIZE);
   localparam int IW     = (IDX_W > 10) ? IDX_W : 10;
   localparam int LEN_W  = $clog2(SIZE + 1);
   localparam int MEM_D  = 4 * SIZE;
   localparam int NODE_W = $clog2(MEM_D);
   localparam int STK_D  = $clog2(SIZE);
   localparam int STK_W  = $clog2(STK_D + 1);
   localparam int STK_N  = 1 << STK_W;

   typedef struct packed {
      logic [NODE_W-1:0] k;
      logic [IW-1:0]     lo;
      logic [IW-1:0]     hi;
      logic              rdone;
   } frame_type;

   state_type state_ff, state_in;
   logic [1:0]          cmd_ff, cmd_in;
   logic [IW-1:0]       a_ff, a_in, b_ff, b_in;
   logic [63:0]         v_ff, v_in, acc_ff, acc_in;
   logic [NODE_W-1:0]   cur_k_ff, cur_k_in;
   logic [IW-1:0]       cur_lo_ff, cur_lo_in, cur_hi_ff, cur_hi_in;
   logic [STK_W-1:0]    sp_ff, sp_in;
   frame_type           stk_ff [0:STK_N-1];
   frame_type           stk_in [0:STK_N-1];
   node_type            node_ff, node_in;
   logic [NODE_W-1:0]   mod_addr_ff, mod_addr_in;
   logic [LEN_W-1:0]    mod_len_ff, mod_len_in;
   logic                mod_asg_ff, mod_asg_in;
   logic [63:0]         mod_w_ff, mod_w_in;
   kind_type            mod_kind_ff, mod_kind_in;
   logic [63:0]         prod_ff, prod_in, tmp_ff, tmp_in;
   logic [NODE_W-1:0]   clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [63:0]         rsp_sum_ff, rsp_sum_in;

   node_type            mem [0:MEM_D-1];
   node_type            rdata_ff;
   logic [NODE_W-1:0]   raddr_c, waddr_c;
   node_type            wdata_c;
   logic                we_c;

   logic [IW-1:0]       mid_c, top_mid_c, req_a_c, req_b_c;
   logic [STK_W-1:0]    top_idx_c;
   frame_type           top_c;
   logic                disjoint_c, covered_c, rsp_free_c;
   logic [31:0]         mul_a_c;
   logic [32+LEN_W-1:0] mul_c;

   assign mid_c     = cur_lo_ff + ((cur_hi_ff - cur_lo_ff) >> 1);
   assign top_idx_c = sp_ff - STK_W'(1);
   assign top_c     = stk_ff[top_idx_c];
   assign top_mid_c = top_c.lo + ((top_c.hi - top_c.lo) >> 1);
   assign disjoint_c = (b_ff < cur_lo_ff) || (a_ff > cur_hi_ff);
   assign covered_c  = (a_ff <= cur_lo_ff) && (cur_hi_ff <= b_ff);
   assign req_a_c    = IW'(req_ch.range_start);
   assign req_b_c    = (IW'(req_ch.range_end) > IW'(SIZE - 1)) ? IW'(SIZE - 1)
                                                              : IW'(req_ch.range_end);
   assign rsp_free_c = !rsp_valid_ff || rsp_ch.ready;

   // Shared multiplier: low half of the operand first, then the high half.
   assign mul_a_c = (state_ff == ST_MRD) ? mod_w_ff[31:0] : mod_w_ff[63:32];
   assign mul_c   = {{LEN_W{1'b0}}, mul_a_c} * {{32{1'b0}}, mod_len_ff};

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.range_sum = rsp_sum_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == NODE_W'(MEM_D - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.command == CMD_NONE) begin
                  state_in = ST_IDLE;
               end else if (req_a_c > req_b_c) begin
                  state_in = (req_ch.command == CMD_QUERY) ? ST_DONE : ST_IDLE;
               end else begin
                  state_in = ST_VISIT;
               end
            end
         end
         ST_VISIT: state_in = disjoint_c ? ST_RET : ST_NODE;
         ST_NODE: begin
            if (covered_c && cmd_ff == CMD_QUERY) state_in = ST_RET;
            else state_in = ST_MRD;
         end
         ST_MRD:  state_in = ST_MMUL;
         ST_MMUL: state_in = ST_MWR;
         ST_MWR: begin
            case (mod_kind_ff)
               KIND_COVER: state_in = ST_RET;
               KIND_LEFT:  state_in = ST_MRD;
               KIND_RIGHT: state_in = ST_PUSHP;
               default:    state_in = ST_RET;
            endcase
         end
         ST_PUSHP: state_in = ST_VISIT;
         ST_RET: begin
            if (sp_ff == '0) begin
               state_in = (cmd_ff == CMD_QUERY) ? ST_DONE : ST_IDLE;
            end else if (!top_c.rdone) begin
               state_in = ST_VISIT;
            end else if (cmd_ff != CMD_QUERY) begin
               state_in = ST_POSTL;
            end else begin
               state_in = ST_RET;
            end
         end
         ST_POSTL: state_in = ST_POSTR;
         ST_POSTR: state_in = ST_POSTW;
         ST_POSTW: state_in = ST_RET;
         ST_DONE:  if (rsp_free_c) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      cmd_in       = cmd_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      v_in         = v_ff;
      acc_in       = acc_ff;
      cur_k_in     = cur_k_ff;
      cur_lo_in    = cur_lo_ff;
      cur_hi_in    = cur_hi_ff;
      sp_in        = sp_ff;
      stk_in       = stk_ff;
      node_in      = node_ff;
      mod_addr_in  = mod_addr_ff;
      mod_len_in   = mod_len_ff;
      mod_asg_in   = mod_asg_ff;
      mod_w_in     = mod_w_ff;
      mod_kind_in  = mod_kind_ff;
      prod_in      = prod_ff;
      tmp_in       = tmp_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_sum_in   = rsp_sum_ff;
      raddr_c      = mod_addr_ff;
      waddr_c      = mod_addr_ff;
      wdata_c      = apply_node(rdata_ff, mod_asg_ff, mod_w_ff, prod_ff);
      we_c         = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            waddr_c = clr_ff;
            wdata_c = '0;
            we_c    = 1'b1;
            clr_in  = clr_ff + NODE_W'(1);
         end
         ST_IDLE: begin
            cmd_in    = req_ch.command;
            a_in      = req_a_c;
            b_in      = req_b_c;
            v_in      = 64'(req_ch.value);
            acc_in    = '0;
            sp_in     = '0;
            cur_k_in  = NODE_W'(1);
            cur_lo_in = '0;
            cur_hi_in = IW'(SIZE - 1);
         end
         ST_VISIT: raddr_c = cur_k_ff;
         ST_NODE: begin
            if (covered_c) begin
               acc_in      = acc_ff + rdata_ff.sum;
               mod_addr_in = cur_k_ff;
               mod_len_in  = LEN_W'(({1'b0, cur_hi_ff} - {1'b0, cur_lo_ff}) + 1'b1);
               mod_asg_in  = (cmd_ff == CMD_ASSIGN);
               mod_w_in    = v_ff;
               mod_kind_in = KIND_COVER;
            end else begin
               // Push the pending update down to both children first.
               node_in     = rdata_ff;
               mod_addr_in = {cur_k_ff[NODE_W-2:0], 1'b0};
               mod_len_in  = LEN_W'(({1'b0, mid_c} - {1'b0, cur_lo_ff}) + 1'b1);
               mod_asg_in  = rdata_ff.flag;
               mod_w_in    = rdata_ff.flag ? rdata_ff.pend_asg : rdata_ff.pend_add;
               mod_kind_in = KIND_LEFT;
            end
         end
         ST_MRD:  prod_in = 64'(mul_c);
         ST_MMUL: prod_in = prod_ff + {mul_c[31:0], 32'd0};
         ST_MWR: begin
            we_c = 1'b1;
            if (mod_kind_ff == KIND_LEFT) begin
               mod_addr_in = {cur_k_ff[NODE_W-2:0], 1'b1};
               mod_len_in  = LEN_W'({1'b0, cur_hi_ff} - {1'b0, mid_c});
               mod_kind_in = KIND_RIGHT;
            end
         end
         ST_PUSHP: begin
            waddr_c        = cur_k_ff;
            wdata_c        = '0;
            wdata_c.sum    = node_ff.sum;
            we_c           = 1'b1;
            stk_in[sp_ff]  = '{k: cur_k_ff, lo: cur_lo_ff, hi: cur_hi_ff, rdone: 1'b0};
            sp_in          = sp_ff + STK_W'(1);
            cur_k_in       = {cur_k_ff[NODE_W-2:0], 1'b0};
            cur_hi_in      = mid_c;
         end
         ST_RET: begin
            if (sp_ff != '0) begin
               if (!top_c.rdone) begin
                  stk_in[top_idx_c].rdone = 1'b1;
                  cur_k_in  = {top_c.k[NODE_W-2:0], 1'b1};
                  cur_lo_in = top_mid_c + IW'(1);
                  cur_hi_in = top_c.hi;
               end else if (cmd_ff == CMD_QUERY) begin
                  sp_in = top_idx_c;
               end
            end
         end
         ST_POSTL: raddr_c = {top_c.k[NODE_W-2:0], 1'b0};
         ST_POSTR: begin
            raddr_c = {top_c.k[NODE_W-2:0], 1'b1};
            tmp_in  = rdata_ff.sum;
         end
         ST_POSTW: begin
            waddr_c     = top_c.k;
            wdata_c     = '0;
            wdata_c.sum = tmp_ff + rdata_ff.sum;
            we_c        = 1'b1;
            sp_in       = top_idx_c;
         end
         ST_DONE: begin
            if (rsp_free_c) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = acc_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we_c) begin
         mem[waddr_c] <= wdata_c;
      end
      rdata_ff <= mem[raddr_c];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      v_ff        <= v_in;
      acc_ff      <= acc_in;
      cur_k_ff    <= cur_k_in;
      cur_lo_ff   <= cur_lo_in;
      cur_hi_ff   <= cur_hi_in;
      stk_ff      <= stk_in;
      node_ff     <= node_in;
      mod_addr_ff <= mod_addr_in;
      mod_len_ff  <= mod_len_in;
      mod_asg_ff  <= mod_asg_in;
      mod_w_ff    <= mod_w_in;
      mod_kind_ff <= mod_kind_in;
      prod_ff     <= prod_in;
      tmp_ff      <= tmp_in;
      rsp_sum_ff  <= rsp_sum_in;
   end

   `RAST_ASSERT_NOW(a_stack_bound, clock, reset, 1'b1, sp_ff <= STK_W'(STK_D), "stack overflow")
   `RAST_ASSERT_NOW(a_idle_empty, clock, reset, state_ff == ST_IDLE, sp_ff == '0, "stack not empty")
   `RAST_ASSERT_NOW(a_clear_quiet, clock, reset, state_ff == ST_CLEAR, !rsp_valid_ff, "rsp in clear")
   `RAST_ASSERT_NEXT(a_done_loads, clock, reset, state_ff == ST_DONE && rsp_free_c, rsp_valid_ff, "rsp lost")

endmodule
